### rtl/rob_pkg.sv
// rob_pkg: shared types, constants and ring-pointer helpers for the reorder buffer.
// Used by rob_ctrl, rob_datapath and reorder_buffer. No dependencies.

package rob_pkg;

   localparam int DEPTH  = 32;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SLOT_W = 5;

   localparam logic [2:0] KIND_ALLOC    = 3'd0;
   localparam logic [2:0] KIND_COMPLETE = 3'd1;
   localparam logic [2:0] KIND_RETIRE   = 3'd2;
   localparam logic [2:0] KIND_FLUSH    = 3'd3;
   localparam logic [2:0] KIND_READ     = 3'd4;

   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        pc;
      logic [7:0]         tag;
      logic [3:0]         flags;
      logic [3:0]         status_code;
      logic signed [31:0] value;
      logic [4:0]         slot;
   } rob_req_type;

   typedef struct packed {
      logic               ok;
      logic [4:0]         slot_out;
      logic [31:0]        out_pc;
      logic signed [31:0] out_value;
      logic [3:0]         out_flags;
      logic [3:0]         out_status;
      logic               is_full;
      logic               is_empty;
   } rob_rsp_type;

   typedef struct packed {
      logic [31:0] pc;
      logic [7:0]  tag;
   } rob_key_type;

   typedef struct packed {
      logic [3:0]         flags;
      logic [3:0]         status_code;
      logic signed [31:0] value;
   } rob_data_type;

   localparam int KEY_W  = $bits(rob_key_type);
   localparam int DATA_W = $bits(rob_data_type);

   // controller -> datapath
   typedef struct packed {
      logic latch;
      logic alloc;
      logic flush;
      logic reply_nop;
      logic read_head;
      logic read_slot;
      logic scan_first;
      logic scan_next;
      logic scan_hit;
      logic reply_retire;
      logic reply_read;
   } rob_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic scan_match;
      logic scan_last;
   } rob_sts_type;

   function automatic ptr_type ring_next(input ptr_type i);
      if (i == ptr_type'(DEPTH - 1)) begin
         return '0;
      end
      return i + ptr_type'(1);
   endfunction

   // forward distance from h to i around the ring
   function automatic ptr_type ring_dist(input ptr_type i, input ptr_type h);
      logic [PTR_W:0] sum;
      sum = {1'b0, i} + (PTR_W + 1)'(DEPTH) - {1'b0, h};
      if (sum >= (PTR_W + 1)'(DEPTH)) begin
         sum = sum - (PTR_W + 1)'(DEPTH);
      end
      return ptr_type'(sum);
   endfunction

   function automatic logic slot_in_range(input logic [SLOT_W-1:0] s);
      return int'(s) < DEPTH;
   endfunction

   function automatic ptr_type to_ptr(input logic [SLOT_W-1:0] s);
      return ptr_type'(s);
   endfunction

   function automatic logic [SLOT_W-1:0] to_slot(input ptr_type p);
      return SLOT_W'(p);
   endfunction

endpackage

### rtl/reorder_buffer.sv
// reorder_buffer: circular reorder buffer, top level.
// Depends on rob_pkg, rob_ctrl, rob_datapath (and rob_ram through the datapath).
//
//   channel   ports                        direction  handshake
//   request   start, busy, req_item        in         taken when start && !busy
//   response  rsp_valid, rsp_item          out        one-cycle strobe, no backpressure
//
// Allocate, flush, unknown kinds, and retire/complete on an empty buffer: the
// response appears the cycle after the request and busy stays low.
// Retire and read flags: one RAM read, busy in S_RETIRE or S_READ, then a registered response.
// Complete: entries are compared one per cycle from the head (one RAM read port),
// busy while the scan runs; at most DEPTH entries are checked.
// Synchronous reset empties the buffer; entry contents are not cleared.

module reorder_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rob_pkg::rob_req_type req_item,
   output logic                 rsp_valid,
   output rob_pkg::rob_rsp_type rsp_item
);
   import rob_pkg::*;

   rob_cmd_type cmd;
   rob_sts_type sts;

   rob_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_kind(req_item.kind),
      .sts     (sts),
      .cmd     (cmd),
      .busy    (busy)
   );

   rob_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

endmodule

### rtl/rob_ram.sv
// rob_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module rob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rob_ctrl.sv
// rob_ctrl: request sequencer for the reorder buffer.
// Depends on rob_pkg; drives rob_datapath through rob_cmd_type.

module rob_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_kind,
   input  rob_pkg::rob_sts_type sts,
   output rob_pkg::rob_cmd_type cmd,
   output logic                 busy
);
   import rob_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_RETIRE = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_SCAN   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               unique case (req_kind)
                  KIND_ALLOC: cmd.alloc = 1'b1;
                  KIND_FLUSH: cmd.flush = 1'b1;
                  KIND_COMPLETE: begin
                     if (sts.empty) begin
                        cmd.reply_nop = 1'b1;
                     end else begin
                        cmd.scan_first = 1'b1;
                        state_in       = S_SCAN;
                     end
                  end
                  KIND_RETIRE: begin
                     if (sts.empty) begin
                        cmd.reply_nop = 1'b1;
                     end else begin
                        cmd.read_head = 1'b1;
                        state_in      = S_RETIRE;
                     end
                  end
                  KIND_READ: begin
                     cmd.read_slot = 1'b1;
                     state_in      = S_READ;
                  end
                  default: cmd.reply_nop = 1'b1;
               endcase
            end
         end
         S_RETIRE: begin
            cmd.reply_retire = 1'b1;
            state_in         = S_IDLE;
         end
         S_READ: begin
            cmd.reply_read = 1'b1;
            state_in       = S_IDLE;
         end
         S_SCAN: begin
            if (sts.scan_match) begin
               cmd.scan_hit = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.scan_last) begin
               cmd.reply_nop = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### rtl/rob_datapath.sv
// rob_datapath: ring pointers, entry state flags, entry RAMs and response register.
// Depends on rob_pkg and rob_ram; controlled by rob_ctrl.

module rob_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rob_pkg::rob_req_type req_item,
   input  rob_pkg::rob_cmd_type cmd,
   output rob_pkg::rob_sts_type sts,
   output logic                 rsp_valid,
   output rob_pkg::rob_rsp_type rsp_item
);
   import rob_pkg::*;

   ptr_type      head_ff, head_in;
   ptr_type      tail_ff, tail_in;
   logic         empty_ff, empty_in;
   logic [1:0]   state_ff [DEPTH];
   logic [1:0]   state_in [DEPTH];
   ptr_type      scan_ff, scan_in;
   rob_req_type  req_ff, req_in;
   rob_rsp_type  rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic         key_we, data_we;
   ptr_type      key_wa, data_wa, rd_addr;
   rob_key_type  key_wd, key_rd;
   rob_data_type data_wd, data_rd;

   logic         full_now;
   logic         flush_ok;
   ptr_type      port_ptr;
   ptr_type      dist_port, dist_tail;
   logic [DEPTH-1:0] flush_kill;

   assign port_ptr  = to_ptr(req_item.slot);
   assign dist_port = ring_dist(port_ptr, head_ff);
   assign dist_tail = ring_dist(tail_ff, head_ff);
   assign full_now  = !empty_ff && (ring_next(tail_ff) == head_ff);
   assign flush_ok  = slot_in_range(req_item.slot) && !empty_ff && (dist_port <= dist_tail);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         flush_kill[i] = (ring_dist(ptr_type'(i), head_ff) > dist_port) &&
                         (ring_dist(ptr_type'(i), head_ff) <= dist_tail);
      end
   end

   always_comb begin
      if (cmd.read_head || cmd.scan_first) begin
         rd_addr = head_ff;
      end else if (cmd.read_slot) begin
         rd_addr = port_ptr;
      end else if (cmd.scan_next) begin
         rd_addr = ring_next(scan_ff);
      end else begin
         rd_addr = scan_ff;
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      state_in     = state_ff;
      scan_in      = scan_ff;
      req_in       = cmd.latch ? req_item : req_ff;
      key_we       = 1'b0;
      key_wa       = tail_ff;
      key_wd       = {req_item.pc, req_item.tag};
      data_we      = 1'b0;
      data_wa      = scan_ff;
      data_wd      = '0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      if (cmd.alloc) begin
         rsp_valid_in = 1'b1;
         if (!full_now) begin
            if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
            end else begin
               tail_in = ring_next(tail_ff);
            end
            state_in[tail_in] = ST_ALLOC;
            key_we          = 1'b1;
            key_wa          = tail_in;
            data_we         = 1'b1;
            data_wa         = tail_in;
            rsp_in.ok       = 1'b1;
            rsp_in.slot_out = to_slot(tail_in);
         end
      end

      if (cmd.flush) begin
         rsp_valid_in = 1'b1;
         if (flush_ok) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (flush_kill[i]) begin
                  state_in[i] = ST_FREE;
               end
            end
            tail_in   = port_ptr;
            rsp_in.ok = 1'b1;
         end
      end

      if (cmd.scan_first) begin
         scan_in = head_ff;
      end
      if (cmd.scan_next) begin
         scan_in = ring_next(scan_ff);
      end

      if (cmd.scan_hit) begin
         rsp_valid_in      = 1'b1;
         data_we           = 1'b1;
         data_wa           = scan_ff;
         data_wd           = {req_ff.flags, req_ff.status_code, req_ff.value};
         state_in[scan_ff] = ST_DONE;
         rsp_in.ok         = 1'b1;
         rsp_in.slot_out   = to_slot(scan_ff);
      end

      if (cmd.reply_retire) begin
         rsp_valid_in      = 1'b1;
         rsp_in.ok         = 1'b1;
         rsp_in.slot_out   = to_slot(head_ff);
         rsp_in.out_pc     = key_rd.pc;
         rsp_in.out_value  = data_rd.value;
         rsp_in.out_flags  = data_rd.flags;
         rsp_in.out_status = data_rd.status_code;
         state_in[head_ff] = ST_FREE;
         if (head_ff == tail_ff) begin
            empty_in = 1'b1;
            head_in  = '0;
            tail_in  = '0;
         end else begin
            head_in = ring_next(head_ff);
         end
      end

      if (cmd.reply_read) begin
         rsp_valid_in = 1'b1;
         if (slot_in_range(req_ff.slot) && (state_ff[to_ptr(req_ff.slot)] != ST_FREE)) begin
            rsp_in.ok        = 1'b1;
            rsp_in.out_flags = data_rd.flags;
         end
      end

      if (cmd.reply_nop) begin
         rsp_valid_in = 1'b1;
      end

      rsp_in.is_empty = empty_in;
      rsp_in.is_full  = !empty_in && (ring_next(tail_in) == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            state_ff[i] <= ST_FREE;
         end
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end

   rob_ram #(
      .WIDTH(KEY_W),
      .DEPTH(DEPTH)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (key_we),
      .wr_addr(key_wa),
      .wr_data(key_wd),
      .rd_addr(rd_addr),
      .rd_data(key_rd)
   );

   rob_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_data_ram (
      .clock  (clock),
      .wr_en  (data_we),
      .wr_addr(data_wa),
      .wr_data(data_wd),
      .rd_addr(rd_addr),
      .rd_data(data_rd)
   );

   assign sts.empty      = empty_ff;
   assign sts.scan_match = (state_ff[scan_ff] != ST_FREE) &&
                           (key_rd == {req_ff.pc, req_ff.tag});
   assign sts.scan_last  = (scan_ff == tail_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
